// File: rtl/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants of the bitmap shape filler: command codes,
// sequencer states, the command record and the coordinate type.
// ----------------------------------------------------------------------------
`default_nettype none

package bsf_pkg;

    // command codes carried in the input tuser
    typedef enum logic [2:0] {
        ACT_CLEAR   = 3'd0,
        ACT_POINT   = 3'd1,
        ACT_RECT    = 3'd2,
        ACT_DIAMOND = 3'd3,
        ACT_DUMP    = 3'd4
    } t_action;

    // configuration register indexes
    localparam logic [1:0] CFG_ACTIVE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_HEIGHT = 2'd1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_DUMP
    } t_state;

    // fixed field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int AW_REG_W   = 6;
    localparam int AH_REG_W   = 5;
    localparam int IN_TDATA_W = 40;
    localparam int ROW_BITS_W = 32;
    localparam int ROW_IDX_W  = 4;
    localparam int OUT_TDATA_W = 40;

    // signed working coordinate, wide enough for centre plus or minus radius
    localparam int COORD_W = 10;
    typedef logic signed [COORD_W-1:0] t_coord;

    // one accepted command
    typedef struct packed {
        logic [2:0]        action;
        logic signed [7:0] x_pos;
        logic signed [7:0] y_pos;
        logic signed [7:0] width;
        logic signed [7:0] height;
        logic signed [7:0] radius;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/bitmap_shape_filler_top.sv
// Draw: one memory read per active row and the last write-back in the cycle after it,
//   so the next command can transfer only once that last write-back is done.
// Dump: each row word is read from memory and then registered for output, one row
//   per cycle while the output does not stall.
// Clear and ignored codes stay in idle. Reset: synchronous, active low; rows read
//   as clear through per-row valid flags (no clearing pass), width and height 32 and 16.
// ----------------------------------------------------------------------------
// bitmap_shape_filler_top
// One-bit-per-pixel bitmap in a row memory; fills points, rectangles and
// diamonds row by row with read-modify-write, and dumps the active rows.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_shape_filler_top #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // command stream
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: x_pos[7:0], y_pos[15:8], width[23:16], height[31:24], radius[39:32]
    input  wire logic [bsf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: action[2:0]
    input  wire logic [2:0]                         i_s_axis_tuser,
    // row stream
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: row_bits[31:0], row_index[35:32], zero[39:36]
    output logic      [bsf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tlast: last_row
    output logic                                    o_m_axis_tlast,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bsf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);

    bsf_pkg::t_state                  r_state, n_state;
    bsf_pkg::t_cmd                    r_cmd;
    bsf_pkg::t_cmd                    in_cmd;
    logic [ROW_AW-1:0]                r_row, n_row;
    logic                             r_dump_more, n_dump_more;
    logic                             r_pend;
    logic [ROW_AW-1:0]                r_pend_row;
    logic                             r_wr_en, n_wr_en;
    logic [ROW_AW-1:0]                r_wr_row;
    logic [MAX_WIDTH-1:0]             r_wr_mask;
    logic [MAX_HEIGHT-1:0]            r_valid;
    logic                             r_out_valid;
    logic [bsf_pkg::ROW_BITS_W-1:0]   r_out_bits;
    logic [bsf_pkg::ROW_IDX_W-1:0]    r_out_idx;
    logic                             r_out_last;
    logic [bsf_pkg::AW_REG_W-1:0]     r_cfg_aw;
    logic [bsf_pkg::AH_REG_W-1:0]     r_cfg_ah;

    logic [CW-1:0]                    eff_aw;
    logic [HW-1:0]                    eff_ah;
    logic                             in_fire;
    logic                             out_load;
    logic                             rd_issue;
    logic                             dump_issue;
    logic                             clear_all;
    logic                             row_last;
    logic [MAX_WIDTH-1:0]             span_mask;
    logic [MAX_WIDTH-1:0]             col_mask;
    logic [MAX_WIDTH-1:0]             ram_rdata;
    logic [MAX_WIDTH-1:0]             wr_word;
    logic [MAX_WIDTH-1:0]             dump_word;

    // input unpacking
    always_comb begin
        in_cmd.action = i_s_axis_tuser;
        in_cmd.x_pos  = i_s_axis_tdata[7:0];
        in_cmd.y_pos  = i_s_axis_tdata[15:8];
        in_cmd.width  = i_s_axis_tdata[23:16];
        in_cmd.height = i_s_axis_tdata[31:24];
        in_cmd.radius = i_s_axis_tdata[39:32];
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_aw <= bsf_pkg::AW_REG_W'(32);
            r_cfg_ah <= bsf_pkg::AH_REG_W'(16);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bsf_pkg::CFG_ACTIVE_WIDTH) begin
                r_cfg_aw <= i_cfg_data[bsf_pkg::AW_REG_W-1:0];
            end else if (i_cfg_index == bsf_pkg::CFG_ACTIVE_HEIGHT) begin
                r_cfg_ah <= i_cfg_data[bsf_pkg::AH_REG_W-1:0];
            end
        end
    end

    // active area, clamped to 1..max
    always_comb begin
        if (r_cfg_aw == '0) begin
            eff_aw = CW'(1);
        end else if (32'(r_cfg_aw) > MAX_WIDTH) begin
            eff_aw = CW'(MAX_WIDTH);
        end else begin
            eff_aw = CW'(r_cfg_aw);
        end
        if (r_cfg_ah == '0) begin
            eff_ah = HW'(1);
        end else if (32'(r_cfg_ah) > MAX_HEIGHT) begin
            eff_ah = HW'(MAX_HEIGHT);
        end else begin
            eff_ah = HW'(r_cfg_ah);
        end
    end

    // active column mask for dumps
    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            col_mask[i] = (CW'(i) < eff_aw);
        end
    end

    // handshake terms
    assign o_s_axis_tready = (r_state == bsf_pkg::ST_IDLE) && !r_wr_en;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = r_pend && (!r_out_valid || i_m_axis_tready);
    assign row_last        = (HW'(r_row) == eff_ah - HW'(1));

    // row mask of the current shape
    bsf_span #(
        .MAX_WIDTH (MAX_WIDTH),
        .ROW_AW    (ROW_AW),
        .CW        (CW)
    ) u_span (
        .i_cmd  (r_cmd),
        .i_row  (r_row),
        .i_aw   (eff_aw),
        .o_mask (span_mask)
    );

    // row memory
    assign wr_word   = (r_valid[r_wr_row] ? ram_rdata : '0) | r_wr_mask;
    assign dump_word = (r_valid[r_pend_row] ? ram_rdata : '0) & col_mask;

    bsf_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT),
        .AW    (ROW_AW)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (r_wr_en),
        .i_waddr (r_wr_row),
        .i_wdata (wr_word),
        .i_re    (rd_issue),
        .i_raddr (r_row),
        .o_rdata (ram_rdata)
    );

    // sequencer next state and controls
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_dump_more = r_dump_more;
        n_wr_en     = 1'b0;
        rd_issue    = 1'b0;
        dump_issue  = 1'b0;
        clear_all   = 1'b0;
        case (r_state)
            bsf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (in_cmd.action)
                        bsf_pkg::ACT_CLEAR: begin
                            clear_all = 1'b1;
                        end
                        bsf_pkg::ACT_POINT, bsf_pkg::ACT_RECT,
                        bsf_pkg::ACT_DIAMOND: begin
                            n_state = bsf_pkg::ST_DRAW;
                            n_row   = '0;
                        end
                        bsf_pkg::ACT_DUMP: begin
                            n_state     = bsf_pkg::ST_DUMP;
                            n_row       = ROW_AW'(eff_ah - HW'(1));
                            n_dump_more = 1'b1;
                        end
                        default: begin
                            n_state = bsf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bsf_pkg::ST_DRAW: begin
                // read this row, merge and write it back next cycle
                rd_issue = 1'b1;
                n_wr_en  = 1'b1;
                if (row_last) begin
                    n_state = bsf_pkg::ST_IDLE;
                    n_row   = '0;
                end else begin
                    n_row = r_row + ROW_AW'(1);
                end
            end
            bsf_pkg::ST_DUMP: begin
                // one read in flight, held in the memory until the output takes it
                if (r_dump_more && (!r_pend || out_load)) begin
                    rd_issue   = 1'b1;
                    dump_issue = 1'b1;
                    if (r_row == '0) begin
                        n_dump_more = 1'b0;
                    end else begin
                        n_row = r_row - ROW_AW'(1);
                    end
                end
                if (!r_dump_more && !r_pend) begin
                    n_state = bsf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsf_pkg::ST_IDLE;
            end
        endcase
    end

    // state register and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsf_pkg::ST_IDLE;
            r_row       <= '0;
            r_dump_more <= 1'b0;
            r_pend      <= 1'b0;
            r_wr_en     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_dump_more <= n_dump_more;
            r_wr_en     <= n_wr_en;
            if (dump_issue) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end
            if (clear_all) begin
                r_valid <= '0;
            end else if (r_wr_en) begin
                r_valid[r_wr_row] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= in_cmd;
        end
        r_wr_row  <= r_row;
        r_wr_mask <= span_mask;
        if (dump_issue) begin
            r_pend_row <= r_row;
        end
        if (out_load) begin
            r_out_bits <= bsf_pkg::ROW_BITS_W'(dump_word);
            r_out_idx  <= bsf_pkg::ROW_IDX_W'(r_pend_row);
            r_out_last <= (r_pend_row == '0);
        end
    end

    // output stream
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(bsf_pkg::OUT_TDATA_W - bsf_pkg::ROW_BITS_W
                                - bsf_pkg::ROW_IDX_W){1'b0}}, r_out_idx, r_out_bits};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // no command is taken while a write-back is still outstanding
    a_no_accept_during_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_en |-> !o_s_axis_tready)
        else $error("command accepted during write-back");

    // a pending dump read only exists inside a dump
    a_pend_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == bsf_pkg::ST_DUMP))
        else $error("pending row read outside a dump");

    // draw reads stay inside the active rows
    a_draw_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsf_pkg::ST_DRAW) |-> (HW'(r_row) < eff_ah))
        else $error("draw row beyond active height");

    // the last word of a dump is row zero
    a_last_is_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_out_idx == '0))
        else $error("last row mark on a non-zero row");
`endif

endmodule

`default_nettype wire

// File: rtl/bsf_ram.sv
// ----------------------------------------------------------------------------
// bsf_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/bsf_span.sv
// ----------------------------------------------------------------------------
// bsf_span
// Works out the pixels a point, rectangle or diamond covers on one row and
// returns them as a row mask clipped to the active columns.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_span #(
    parameter int MAX_WIDTH = 32,
    parameter int ROW_AW    = 4,
    parameter int CW        = 6
) (
    input  wire bsf_pkg::t_cmd         i_cmd,
    input  wire logic [ROW_AW-1:0]     i_row,
    input  wire logic [CW-1:0]         i_aw,
    output logic      [MAX_WIDTH-1:0]  o_mask
);

    bsf_pkg::t_coord row_c;
    bsf_pkg::t_coord xs;
    bsf_pkg::t_coord ys;
    bsf_pkg::t_coord ws;
    bsf_pkg::t_coord hs;
    bsf_pkg::t_coord rs;
    bsf_pkg::t_coord diff;
    bsf_pkg::t_coord dy;
    bsf_pkg::t_coord rem;
    bsf_pkg::t_coord lo;
    bsf_pkg::t_coord hi;
    logic            hit;

    // operands widened to the working coordinate
    always_comb begin
        row_c = $signed(bsf_pkg::COORD_W'(i_row));
        xs    = bsf_pkg::t_coord'(i_cmd.x_pos);
        ys    = bsf_pkg::t_coord'(i_cmd.y_pos);
        ws    = bsf_pkg::t_coord'(i_cmd.width);
        hs    = bsf_pkg::t_coord'(i_cmd.height);
        rs    = bsf_pkg::t_coord'(i_cmd.radius);
        diff  = row_c - ys;
        dy    = (diff < 0) ? -diff : diff;
        rem   = rs - dy;
    end

    // span of the shape on this row
    always_comb begin
        hit = 1'b0;
        lo  = xs;
        hi  = xs;
        case (i_cmd.action)
            bsf_pkg::ACT_POINT: begin
                hit = (row_c == ys);
            end
            bsf_pkg::ACT_RECT: begin
                hit = (ws > 0) && (hs > 0) && (row_c >= ys)
                      && (row_c <= ys + hs - bsf_pkg::t_coord'(1));
                hi  = xs + ws - bsf_pkg::t_coord'(1);
            end
            bsf_pkg::ACT_DIAMOND: begin
                hit = (rs >= 0) && (rem >= 0);
                lo  = xs - rem;
                hi  = xs + rem;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    // per-column compare, clipped to the active columns
    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            o_mask[i] = hit && (bsf_pkg::t_coord'(i) >= lo)
                        && (bsf_pkg::t_coord'(i) <= hi) && (CW'(i) < i_aw);
        end
    end

endmodule

`default_nettype wire
